// File: src/pli_pkg.sv
package pli_pkg;

  localparam int POS_W  = 8;
  localparam int DATA_W = 32;
  localparam int CNT_OUT_W = 8;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic                     ins;
    logic                     del;
    logic                     load;
    logic                     fold;
    logic [POS_W-1:0]         pos0;
    logic signed [DATA_W-1:0] value;
  } pli_ctrl_t;

endpackage

// File: src/pli_cell.sv
module pli_cell
  import pli_pkg::*;
#(
  parameter int IW    = 7,
  parameter int INDEX = 0
) (
  input  logic                     clk,
  input  pli_ctrl_t                ctrl,
  input  logic signed [DATA_W-1:0] left_entry,
  input  logic signed [DATA_W-1:0] right_entry,
  input  logic signed [DATA_W-1:0] right_tap,
  output logic signed [DATA_W-1:0] entry,
  output logic signed [DATA_W-1:0] tap
);

  localparam int W = (IW > POS_W ? IW : POS_W) + 1;

  logic [W-1:0] idx;
  logic [W-1:0] pos_ix;

  assign idx    = W'(INDEX);
  assign pos_ix = W'(ctrl.pos0);

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (idx > pos_ix) begin
        entry <= left_entry;
      end else if (idx == pos_ix) begin
        entry <= ctrl.value;
      end
    end else if (ctrl.del) begin
      if (idx >= pos_ix) begin
        entry <= right_entry;
      end
    end
  end

  // capture the addressed entry, then fold taps towards cell zero
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      tap <= (idx == pos_ix) ? entry : '0;
    end else if (ctrl.fold) begin
      tap <= tap | right_tap;
    end
  end

endmodule

// File: src/positional_list_insert_delete.sv
// Insert and rejected commands go from acceptance straight to the output state;
//   a successful delete or read at position p first passes the fold state unless p is 1.
// One transaction in flight: no command is accepted until the result is taken, and
//   the next is accepted in the cycle after the result is taken.
// The read latency is set by the tap chain, which folds one cell per cycle.
// Reset (rst, synchronous): clears the length and control; storage is undefined.
module positional_list_insert_delete
  import pli_pkg::*;
#(
  parameter int CAPACITY = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // command[1:0], position[9:2], value[41:10], zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // status[1:0], data_out[33:2], count[41:34], zero
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int DW = (CW > POS_W ? CW : POS_W) + 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_FOLD = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t state, state_next;

  logic [1:0]               command;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] value;

  logic [CW-1:0]  count;
  logic [IW-1:0]  steps;
  status_t        status;
  logic           data_sel;

  logic           accept;
  status_t        status_next;
  logic           ok;
  logic [DW-1:0]  pos_w;
  logic [DW-1:0]  cnt_w;
  pli_ctrl_t      ctrl;

  logic signed [DATA_W-1:0] entry [CAPACITY];
  logic signed [DATA_W-1:0] tap   [CAPACITY];

  assign command  = s_tdata[1:0];
  assign position = s_tdata[9:2];
  assign value    = s_tdata[41:10];

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  assign pos_w = DW'(position);
  assign cnt_w = DW'(count);

  always_comb begin
    case (command)
      CMD_INSERT: begin
        if (position == '0 || pos_w > cnt_w + DW'(1)) begin
          status_next = ST_RANGE;
        end else if (count >= CW'(CAPACITY)) begin
          status_next = ST_FULL;
        end else begin
          status_next = ST_OK;
        end
      end
      CMD_DELETE, CMD_READ: begin
        if (position == '0 || pos_w > cnt_w) begin
          status_next = ST_RANGE;
        end else begin
          status_next = ST_OK;
        end
      end
      default: status_next = ST_RANGE;
    endcase
  end

  assign ok = accept && (status_next == ST_OK);

  always_comb begin
    ctrl.ins   = ok && (command == CMD_INSERT);
    ctrl.del   = ok && (command == CMD_DELETE);
    ctrl.load  = ok && (command == CMD_DELETE || command == CMD_READ);
    ctrl.fold  = (state == S_FOLD);
    ctrl.pos0  = position - POS_W'(1);
    ctrl.value = value;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_entry;
    logic signed [DATA_W-1:0] right_entry;
    logic signed [DATA_W-1:0] right_tap;

    if (i == 0) begin : g_head
      assign left_entry = '0;
    end else begin : g_body
      assign left_entry = entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_entry = '0;
      assign right_tap   = '0;
    end else begin : g_link
      assign right_entry = entry[i+1];
      assign right_tap   = tap[i+1];
    end

    pli_cell #(
      .IW    (IW),
      .INDEX (i)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .right_tap   (right_tap),
      .entry       (entry[i]),
      .tap         (tap[i])
    );
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (ctrl.load && ctrl.pos0 != '0) begin
            state_next = S_FOLD;
          end else begin
            state_next = S_OUT;
          end
        end
      end
      S_FOLD: begin
        if (steps == IW'(1)) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (m_tready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (ctrl.ins) begin
        count <= count + CW'(1);
      end else if (ctrl.del) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status   <= status_next;
      data_sel <= ctrl.load;
      steps    <= IW'(ctrl.pos0);
    end else if (state == S_FOLD) begin
      steps <= steps - IW'(1);
    end
  end

  assign m_tvalid = (state == S_OUT);
  assign m_tdata  = {6'b0, CNT_OUT_W'(count), (data_sel ? tap[0] : '0), status};

endmodule

// File: src/pli_checker.sv
module pli_checker
  import pli_pkg::*;
#(
  parameter int CAPACITY = 128
) (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata
);

  logic [CNT_OUT_W-1:0] cap_out;

  assign cap_out = CNT_OUT_W'(CAPACITY);

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input taken while a result is pending");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result shown straight after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_full_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] == ST_FULL |-> m_tdata[41:34] == cap_out)
    else $error("full status without a full list");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] != ST_OK |-> m_tdata[33:2] == '0)
    else $error("rejected transaction carries data");

endmodule

bind positional_list_insert_delete pli_checker #(
  .CAPACITY (CAPACITY)
) u_pli_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// File: test/testbench.sv
module testbench;
  import pli_pkg::*;

  localparam int CAPACITY = 128;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [1:0] CMD_SPARE = 2'd3;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] data;
    logic [CNT_OUT_W-1:0]     count;
  } list_outcome_t;

  class list_shadow;
    logic signed [DATA_W-1:0] entries[$];
    list_outcome_t outcomes_due[$];
    int errors;
    int full_refusals;
    int peak_length;
    int checked;

    function int length();
      return entries.size();
    endfunction

    function void note_command(logic [1:0] cmd, logic [POS_W-1:0] pos,
                               logic signed [DATA_W-1:0] val);
      list_outcome_t o;
      o.status = ST_RANGE;
      o.data = '0;
      case (cmd)
        CMD_INSERT: begin
          if (pos != 0 && pos <= entries.size() + 1) begin
            if (entries.size() >= CAPACITY) begin
              o.status = ST_FULL;
              full_refusals++;
            end else begin
              entries.insert(pos - 1, val);
              o.status = ST_OK;
            end
          end
        end
        CMD_DELETE, CMD_READ: begin
          if (pos != 0 && pos <= entries.size()) begin
            o.data = entries[pos - 1];
            o.status = ST_OK;
            if (cmd == CMD_DELETE) entries.delete(pos - 1);
          end
        end
        default: ;
      endcase
      o.count = CNT_OUT_W'(entries.size());
      if (entries.size() > peak_length) peak_length = entries.size();
      outcomes_due.push_back(o);
    endfunction

    function void check_outcome(logic [47:0] tdata);
      list_outcome_t got;
      list_outcome_t want;
      got.status = tdata[1:0];
      got.data = tdata[33:2];
      got.count = tdata[41:34];
      if (outcomes_due.size() == 0) begin
        $error("result transaction with no command outstanding: %h", tdata);
        errors++;
        return;
      end
      want = outcomes_due.pop_front();
      checked++;
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.data !== want.data) begin
        $error("data_out: expected %0d, actual %0d", want.data, got.data);
        errors++;
      end
      if (got.count !== want.count) begin
        $error("count: expected %0d, actual %0d", want.count, got.count);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;   // command[1:0], position[9:2], value[41:10], zero
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;        // status[1:0], data_out[33:2], count[41:34], zero

  list_shadow list_model = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int n_accepted = 0;
  bit held_off = 1'b0;

  positional_list_insert_delete #(.CAPACITY(CAPACITY)) i_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic send_command(input logic [1:0] cmd, input logic [POS_W-1:0] pos,
                              input logic signed [DATA_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'd0, val, pos, cmd};
    do @(posedge clk); while (!s_tready);
    list_model.note_command(cmd, pos, val);
    n_accepted++;
  endtask

  task automatic send_random(input int ins_pct, input int del_pct);
    int n;
    int r;
    logic [1:0] cmd;
    logic [POS_W-1:0] pos;
    logic signed [DATA_W-1:0] val;
    n = list_model.length();
    r = $urandom_range(99);
    if (r < 4) cmd = CMD_SPARE;
    else if (r < 4 + ins_pct) cmd = CMD_INSERT;
    else if (r < 4 + ins_pct + del_pct) cmd = CMD_DELETE;
    else cmd = CMD_READ;
    if ($urandom_range(99) < 15) pos = POS_W'($urandom_range(255));
    else if (cmd == CMD_INSERT) pos = POS_W'($urandom_range(n + 1, 1));
    else pos = (n == 0) ? POS_W'(1) : POS_W'($urandom_range(n, 1));
    case ($urandom_range(19))
      0: val = 32'h7fff_ffff;
      1: val = 32'h8000_0000;
      2: val = '0;
      3: val = '1;
      default: val = $urandom;
    endcase
    send_command(cmd, pos, val);
  endtask

  // Receiver: check each result transaction, apply back-pressure.
  initial begin
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) list_model.check_outcome(m_tdata);
      if (!held_off && n_accepted >= 150) begin
        held_off = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("no transaction for %0d cycles", STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    int guard;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty list, bad positions, extremes of value, spare command.
    send_command(CMD_READ,   8'd1,   32'd0);
    send_command(CMD_DELETE, 8'd1,   32'd0);
    send_command(CMD_INSERT, 8'd0,   32'd5);
    send_command(CMD_INSERT, 8'd2,   32'd6);
    send_command(CMD_INSERT, 8'd1,   32'h7fff_ffff);
    send_command(CMD_INSERT, 8'd1,   32'h8000_0000);
    send_command(CMD_INSERT, 8'd3,   32'hffff_ffff);
    send_command(CMD_INSERT, 8'd2,   32'd0);
    send_command(CMD_READ,   8'd0,   32'd0);
    send_command(CMD_READ,   8'd4,   32'd0);
    send_command(CMD_READ,   8'd5,   32'd0);
    send_command(CMD_READ,   8'd255, 32'd0);
    send_command(CMD_DELETE, 8'd0,   32'd0);
    send_command(CMD_SPARE,  8'd1,   32'h1234_5678);
    send_command(CMD_INSERT, 8'd129, 32'd9);
    send_command(CMD_DELETE, 8'd4,   32'd0);
    send_command(CMD_DELETE, 8'd1,   32'd0);
    send_command(CMD_READ,   8'd2,   32'd0);
    send_command(CMD_DELETE, 8'd2,   32'd0);
    send_command(CMD_DELETE, 8'd1,   32'd0);
    send_command(CMD_READ,   8'd1,   32'd0);

    // Sender sparse, receiver sparser: fill to capacity, refuse, drain.
    send_idle_pct = 27;
    recv_idle_pct = 61;
    guard = 0;
    while (list_model.length() < CAPACITY && guard < 600) begin
      send_random(90, 3);
      guard++;
    end
    repeat (8) send_random(96, 0);
    repeat (40) send_random(40, 30);
    guard = 0;
    while (list_model.length() > 0 && guard < 600) begin
      send_random(8, 80);
      guard++;
    end

    send_idle_pct = 61;
    recv_idle_pct = 27;
    repeat (180) send_random(50, 25);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (180) send_random(40, 35);
    s_tvalid <= 1'b0;

    while (list_model.outcomes_due.size() != 0) @(posedge clk);
    repeat (CAPACITY + 16) @(posedge clk);

    $display("%0d commands and %0d results checked, peak length %0d of %0d",
             n_accepted, list_model.checked, list_model.peak_length, CAPACITY);
    $display("%0d inserts refused on a full list, output held off for %0d cycles",
             list_model.full_refusals, HOLD_CYCLES);
    if (list_model.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
